// File: rtl/pli_pkg.sv
`timescale 1ns / 1ps
// pli_pkg: shared types, constants and helpers for the positional list block
// used by every module under rtl/, depends on nothing else
package pli_pkg;

   localparam int DEPTH       = 64;
   localparam int VALUE_WIDTH = 32;
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int POS_W       = 7;
   localparam int CMP_W       = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   typedef enum logic [2:0] {
      FUNC_INS_FRONT = 3'd0,
      FUNC_INS_END   = 3'd1,
      FUNC_INS_POS   = 3'd2,
      FUNC_DEL_FRONT = 3'd3,
      FUNC_DEL_END   = 3'd4,
      FUNC_DEL_POS   = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_IGNORED = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0]         func;
      logic [POS_W-1:0]   position;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [6:0]         size_after;
      logic signed [31:0] removed_value;
   } rsp_type;

   // shift command broadcast from control to every cell
   typedef struct packed {
      logic                   ins;
      logic                   del;
      logic [IDX_W-1:0]       slot;
      logic [VALUE_WIDTH-1:0] value;
   } shift_cmd_type;

   // input value to stored width: keep low bits or sign-extend
   function automatic logic [VALUE_WIDTH-1:0] to_store(input logic signed [31:0] v);
      logic signed [63:0] w;
      w = 64'(v);
      return w[VALUE_WIDTH-1:0];
   endfunction

   // stored value back to 32 bits, sign-extended from the stored width
   function automatic logic signed [31:0] from_store(input logic [VALUE_WIDTH-1:0] v);
      logic signed [63:0] w;
      w = 64'($signed(v));
      return w[31:0];
   endfunction

endpackage

// File: rtl/pli_cell.sv
`timescale 1ns / 1ps
// pli_cell: one list element, shifts to or from its neighbors on a command
// depends on pli_pkg
module pli_cell
   import pli_pkg::*;
(
   input  logic                   clock,
   input  logic [IDX_W-1:0]       cell_idx,
   input  shift_cmd_type          cmd,
   input  logic [VALUE_WIDTH-1:0] left_value,
   input  logic [VALUE_WIDTH-1:0] right_value,
   output logic [VALUE_WIDTH-1:0] cell_value,
   output logic [VALUE_WIDTH-1:0] hit_value
);

   logic [VALUE_WIDTH-1:0] elem_ff;
   logic [VALUE_WIDTH-1:0] elem_in;

   // next element: open a gap, close a gap or hold
   always_comb begin
      elem_in = elem_ff;
      if (cmd.ins) begin
         if (cell_idx > cmd.slot) begin
            elem_in = left_value;
         end else if (cell_idx == cmd.slot) begin
            elem_in = cmd.value;
         end
      end else if (cmd.del) begin
         if (cell_idx >= cmd.slot) begin
            elem_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      elem_ff <= elem_in;
   end

   assign cell_value = elem_ff;
   // drives the read bus only when this cell is addressed
   assign hit_value  = (cell_idx == cmd.slot) ? elem_ff : '0;

endmodule

// File: rtl/pli_ctrl.sv
`timescale 1ns / 1ps
// pli_ctrl: request decode, element count and result register
// depends on pli_pkg
module pli_ctrl
   import pli_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic [VALUE_WIDTH-1:0] read_value,
   output shift_cmd_type          cmd
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_data_ff;
   rsp_type          rsp_data_in;

   logic             accept;
   logic             is_ins;
   logic             pos_ok;
   logic             full;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] cnt_ext;
   logic [CMP_W-1:0] slot_ext;
   status_type       status;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign pos_ext   = CMP_W'(req_data.position);
   assign cnt_ext   = CMP_W'(count_ff);
   assign full      = (cnt_ext == CMP_W'(DEPTH));

   // decode function into kind, legality and target slot
   always_comb begin
      is_ins   = 1'b0;
      pos_ok   = 1'b0;
      slot_ext = '0;
      case (req_data.func)
         FUNC_INS_FRONT: begin
            is_ins = 1'b1;
            pos_ok = 1'b1;
         end
         FUNC_INS_END: begin
            is_ins   = 1'b1;
            pos_ok   = 1'b1;
            slot_ext = cnt_ext;
         end
         FUNC_INS_POS: begin
            is_ins   = 1'b1;
            pos_ok   = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
            slot_ext = pos_ext - CMP_W'(1);
         end
         FUNC_DEL_FRONT: begin
            pos_ok = (cnt_ext != '0);
         end
         FUNC_DEL_END: begin
            pos_ok   = (cnt_ext != '0);
            slot_ext = cnt_ext - CMP_W'(1);
         end
         FUNC_DEL_POS: begin
            pos_ok   = (pos_ext != '0) && (pos_ext <= cnt_ext);
            slot_ext = pos_ext - CMP_W'(1);
         end
         default: begin
            pos_ok = 1'b0;
         end
      endcase
   end

   // status and the command broadcast to the cells
   always_comb begin
      if (!pos_ok) begin
         status = STATUS_IGNORED;
      end else if (is_ins && full) begin
         status = STATUS_FULL;
      end else begin
         status = STATUS_DONE;
      end
      cmd.ins   = accept && is_ins && pos_ok && !full;
      cmd.del   = accept && !is_ins && pos_ok;
      cmd.slot  = slot_ext[IDX_W-1:0];
      cmd.value = to_store(req_data.value);
   end

   // next count and result beat
   always_comb begin
      count_in = count_ff;
      if (cmd.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.del) begin
         count_in = count_ff - CNT_W'(1);
      end
      rsp_data_in               = rsp_data_ff;
      rsp_valid_in              = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.status        = status;
         rsp_data_in.size_after    = 7'(count_in);
         rsp_data_in.removed_value = cmd.del ? from_store(read_value) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/positional_list_insert_delete.sv
`timescale 1ns / 1ps
// Positional list: ordered list of up to DEPTH values held in a row of cells.
// Request beats (req_valid/req_stall/req_data) insert at front, end or a
// 1-based position, or delete front, end or a position. Each request gives
// exactly one result beat (rsp_valid/rsp_stall/rsp_data): status, size after
// the request and the removed value (zero unless a delete succeeded).
// The result is registered and appears in the cycle after acceptance.
// Throughput: one request per cycle unless stalled; cells at or past the target
// slot shift toward or away from it in the same cycle; the row update sets the rate.
// The removed value is read through an OR bus over all cells before the shift.
// Reset (synchronous, active high) empties the list and drops any pending
// result; cell contents are not cleared and are never read unless written.
// When the receiver stalls, the result holds and req_stall is raised, so no
// new request is taken until the held result is gone.
// depends on pli_pkg, pli_ctrl, pli_cell
module positional_list_insert_delete
   import pli_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   shift_cmd_type          cmd;
   logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
   logic [VALUE_WIDTH-1:0] hit_value  [DEPTH];
   logic [VALUE_WIDTH-1:0] read_value;

   pli_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .read_value (read_value),
      .cmd        (cmd)
   );

   // row of cells, each linked to its neighbors
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      pli_cell u_cell (
         .clock       (clock),
         .cell_idx    (IDX_W'(i)),
         .cmd         (cmd),
         .left_value  (cell_value[(i == 0) ? 0 : i - 1]),
         .right_value (cell_value[(i == DEPTH - 1) ? i : i + 1]),
         .cell_value  (cell_value[i]),
         .hit_value   (hit_value[i])
      );
   end

   // read bus: only the addressed cell drives nonzero
   always_comb begin
      read_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         read_value = read_value | hit_value[i];
      end
   end

endmodule

// File: rtl/pli_checker.sv
`timescale 1ns / 1ps
// pli_checker: port-level checks on the positional list, bound to the top
// depends on pli_pkg and positional_list_insert_delete
module pli_checker
   import pli_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed under stall");

   // every accepted request yields a result beat next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request gave no result");

   // a refused insert only happens at capacity
   a_full_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_FULL) |->
         (rsp_data.size_after == 7'(DEPTH)))
      else $error("full status below capacity");

   // only a completed delete returns a value
   a_removed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STATUS_DONE) |-> (rsp_data.removed_value == '0))
      else $error("removed value on a request that did nothing");

endmodule

bind positional_list_insert_delete pli_checker u_pli_checker (.*);
